// File: sv/emt_pkg.sv
// Package for the emulator master timing unit: field widths, mode and
// register codes, reset values and the shared structs.
// No dependencies.
`default_nettype none

package emt_pkg;

    localparam int MODE_W  = 3;
    localparam int CYC_W   = 32;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 64;
    localparam int LINE_W  = 10;
    localparam int PIX_W   = 12;
    localparam int SAMP_W  = 14;
    localparam int FRAME_W = 32;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_ADD_MAIN  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_GFX   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADD_SOUND = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RUN_FRAME = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ADV_LINE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RECHECK   = 3'd5;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_MAIN_FRAME  = 3'd0;
    localparam logic [IDX_W-1:0] REG_GFX_FRAME   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SOUND_FRAME = 3'd2;
    localparam logic [IDX_W-1:0] REG_VIDEO_FRAME = 3'd3;
    localparam logic [IDX_W-1:0] REG_PIX_LINE    = 3'd4;
    localparam logic [IDX_W-1:0] REG_VIS_LINES   = 3'd5;
    localparam logic [IDX_W-1:0] REG_TOT_LINES   = 3'd6;

    // Configuration reset values.
    localparam logic [CFG_W-1:0]  RST_MAIN_FRAME  = 32'd119318;
    localparam logic [CFG_W-1:0]  RST_GFX_FRAME   = 32'd225000;
    localparam logic [CFG_W-1:0]  RST_SOUND_FRAME = 32'd68266;
    localparam logic [CFG_W-1:0]  RST_VIDEO_FRAME = 32'd225000;
    localparam logic [PIX_W-1:0]  RST_PIX_LINE    = 12'd858;
    localparam logic [LINE_W-1:0] RST_VIS_LINES   = 10'd240;
    localparam logic [LINE_W-1:0] RST_TOT_LINES   = 10'd262;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic [LINE_W-1:0]  scanline;
        logic [PIX_W-1:0]   pixel;
        logic               scanline_event;
        logic               vblank_event;
        logic [SAMP_W-1:0]  new_samples;
        logic [FRAME_W-1:0] frame_number;
        logic               run_main;
        logic               run_graphics;
        logic               run_sound;
        logic [CFG_W-1:0]   frame_samples;
    } t_result;

endpackage

`default_nettype wire

// File: sv/emt_if.sv
// Handshake interfaces of the master timing unit: input items, result items
// and configuration writes. Depends on emt_pkg.
`default_nettype none

interface emt_item_if import emt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [CYC_W-1:0]  cycle_count;

    modport source (output valid, mode, cycle_count, input ready);
    modport sink (input valid, mode, cycle_count, output ready);
endinterface

interface emt_result_if import emt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LINE_W-1:0]  scanline;
    logic [PIX_W-1:0]   pixel;
    logic               scanline_event;
    logic               vblank_event;
    logic [SAMP_W-1:0]  new_samples;
    logic [FRAME_W-1:0] frame_number;
    logic               run_main;
    logic               run_graphics;
    logic               run_sound;
    logic [CFG_W-1:0]   frame_samples;

    modport source (output valid, scanline, pixel, scanline_event, vblank_event,
                    new_samples, frame_number, run_main, run_graphics, run_sound,
                    frame_samples, input ready);
    modport sink (input valid, scanline, pixel, scanline_event, vblank_event,
                  new_samples, frame_number, run_main, run_graphics, run_sound,
                  frame_samples, output ready);
endinterface

interface emt_cfg_if import emt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/emt_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on emt_pkg for the status struct.
`default_nettype none

module emt_serial_div import emt_pkg::*; #(
    parameter int DW = 64,
    parameter int VW = 32,
    localparam int SW = $clog2(DW + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    input  wire logic [SW-1:0] i_steps,
    output t_div_stat          o_stat,
    output logic [DW-1:0]      o_quotient,
    output logic [VW-1:0]      o_remainder
);

    logic [DW-1:0] r_work;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [SW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VW:0]   w_partial;
    logic [VW+1:0] w_diff;
    logic          w_ge;

    // The dividend shifts out MSB first into the partial remainder while
    // quotient bits shift in at the bottom of the same register.
    assign w_partial = {r_rem, r_work[DW-1]};
    assign w_diff    = {1'b0, w_partial} - {2'b00, r_div};
    assign w_ge      = !w_diff[VW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - SW'(1);
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_work <= {r_work[DW-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[VW-1:0] : w_partial[VW-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_work;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// File: sv/emulator_master_timing_unit.sv
// Modes 0, 1 and 5 run two bit-serial beam divisions (64 and 32 steps)
// beside the audio divider; mode 2 runs only the audio divider; modes
// 3, 4, 6 and 7 use neither divider. One item is in work at a time; the next
// is accepted once the result sits in the output register.
// Reset is synchronous and active low; the control state takes its reset value,
// while the item payload and output data registers have no reset.
// Depends on emt_pkg, emt_if.sv and emt_serial_div.
`default_nettype none

module emulator_master_timing_unit import emt_pkg::*; #(
    parameter int CLOCK_HZ    = 13500000,
    parameter int SAMPLE_RATE = 32000
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    emt_item_if.sink    i_item,
    emt_cfg_if.sink     i_cfg,
    emt_result_if.source o_result
);

    // Widths that follow from the clock and sample rate.
    localparam int SR_W    = $clog2(SAMPLE_RATE + 1);
    localparam int CLK_W   = $clog2(CLOCK_HZ + 1);
    localparam int PW      = CNT_W + SR_W;
    localparam int HALF_W  = CNT_W / 2;
    localparam int BSTEP_W = $clog2(CNT_W + 1);
    localparam int ASTEP_W = $clog2(PW + 1);
    localparam logic [SR_W-1:0]  SR_K  = SR_W'(SAMPLE_RATE);
    localparam logic [CLK_W-1:0] CLK_K = CLK_W'(CLOCK_HZ);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ADD  = 6'b000010,
        S_MUL  = 6'b000100,
        S_LOAD = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    // S_DIV also covers the final commit: when every divider in use has reported done,
    // the beam and audio updates are applied in the same cycle.
    t_state r_state, n_state;

    // Configuration registers.
    logic [CFG_W-1:0]  r_main_fc, r_gfx_fc, r_snd_fc, r_video_fc;
    logic [PIX_W-1:0]  r_ppl;
    logic [LINE_W-1:0] r_vis, r_total;

    // Timing state.
    logic [CNT_W-1:0]   r_main_cnt, r_gfx_cnt, r_snd_cnt;
    logic [CNT_W-1:0]   r_main_tgt, r_gfx_tgt, r_snd_tgt;
    logic [FRAME_W-1:0] r_frame;
    logic [LINE_W-1:0]  r_line;
    logic [PIX_W-1:0]   r_pixel;
    logic [CNT_W-1:0]   r_emitted;
    logic [CFG_W-1:0]   r_sif;

    // Item in work.
    logic [MODE_W-1:0]  r_mode;
    logic [CYC_W-1:0]   r_cyc;
    logic               r_line_ev, r_vb_ev;
    logic [SAMP_W-1:0]  r_due;
    logic [HALF_W+SR_W-1:0] r_plo, r_phi;
    logic               r_beam_phase;
    logic               r_beam_ok, r_audio_ok;

    // Output register.
    t_result r_out;
    logic    r_out_valid;

    // Divider connections.
    t_div_stat           w_beam_stat, w_aud_stat;
    logic                w_beam_start, w_aud_start;
    logic [CNT_W-1:0]    w_beam_dvd, w_beam_quo;
    logic [CFG_W-1:0]    w_beam_dvs, w_beam_rem;
    logic [BSTEP_W-1:0]  w_beam_steps;
    logic [PW-1:0]       w_aud_dvd, w_aud_quo;
    logic [CLK_W-1:0]    w_aud_rem;

    logic                w_uses_beam;
    logic [CFG_W-1:0]    w_flen;
    logic [PIX_W-1:0]    w_plen;
    logic                w_both_done;
    logic                w_out_free;
    logic [LINE_W-1:0]   w_new_line;
    logic [LINE_W:0]     w_adv_line;
    logic [CNT_W-1:0]    w_expected;
    logic [CNT_W-1:0]    w_due_full;
    logic                w_due_pos;

    assign w_uses_beam = (r_mode == MODE_ADD_MAIN) || (r_mode == MODE_ADD_GFX) ||
                         (r_mode == MODE_RECHECK);

    // A zero frame or line length behaves as a length of one.
    assign w_flen = (r_video_fc == '0) ? CFG_W'(1) : r_video_fc;
    assign w_plen = (r_ppl == '0) ? PIX_W'(1) : r_ppl;

    // Beam unit: first pass takes the master count modulo the frame length,
    // second pass splits that remainder into scanline and pixel.
    assign w_beam_start = ((r_state == S_LOAD) && w_uses_beam) ||
                          ((r_state == S_DIV) && w_beam_stat.done && !r_beam_phase);
    assign w_beam_dvd   = (r_state == S_LOAD) ? r_gfx_cnt : {w_beam_rem, CFG_W'(0)};
    assign w_beam_dvs   = (r_state == S_LOAD) ? w_flen : CFG_W'(w_plen);
    assign w_beam_steps = (r_state == S_LOAD) ? BSTEP_W'(CNT_W) : BSTEP_W'(CFG_W);

    emt_serial_div #(
        .DW(CNT_W),
        .VW(CFG_W)
    ) u_beam_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_beam_start),
        .i_dividend  (w_beam_dvd),
        .i_divisor   (w_beam_dvs),
        .i_steps     (w_beam_steps),
        .o_stat      (w_beam_stat),
        .o_quotient  (w_beam_quo),
        .o_remainder (w_beam_rem)
    );

    // Audio unit: floor(master * SAMPLE_RATE / CLOCK_HZ). The product is
    // built from two half-width multiplies registered in S_MUL.
    assign w_aud_start = (r_state == S_LOAD);
    assign w_aud_dvd   = {r_phi, HALF_W'(0)} + PW'(r_plo);

    emt_serial_div #(
        .DW(PW),
        .VW(CLK_W)
    ) u_audio_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_aud_start),
        .i_dividend  (w_aud_dvd),
        .i_divisor   (CLK_K),
        .i_steps     (ASTEP_W'(PW)),
        .o_stat      (w_aud_stat),
        .o_quotient  (w_aud_quo),
        .o_remainder (w_aud_rem)
    );

    // The expected sample count wraps modulo 2^64 like the counters.
    assign w_expected = w_aud_quo[CNT_W-1:0];
    assign w_due_pos  = w_expected > r_emitted;
    assign w_due_full = w_expected - r_emitted;

    // The scanline saturates at its field maximum.
    assign w_new_line = (|w_beam_quo[CNT_W-1:LINE_W]) ? '1 : w_beam_quo[LINE_W-1:0];
    assign w_adv_line = {1'b0, r_line} + (LINE_W + 1)'(1);

    assign w_both_done = (r_beam_ok || (w_beam_stat.done && r_beam_phase)) &&
                         (r_audio_ok || w_aud_stat.done);
    assign w_out_free  = !r_out_valid || o_result.ready;

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (w_uses_beam || (r_mode == MODE_ADD_SOUND)) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL:  n_state = S_LOAD;
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (w_both_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state: FSM, configuration, timing counters, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_main_fc   <= RST_MAIN_FRAME;
            r_gfx_fc    <= RST_GFX_FRAME;
            r_snd_fc    <= RST_SOUND_FRAME;
            r_video_fc  <= RST_VIDEO_FRAME;
            r_ppl       <= RST_PIX_LINE;
            r_vis       <= RST_VIS_LINES;
            r_total     <= RST_TOT_LINES;
            r_main_cnt  <= '0;
            r_gfx_cnt   <= '0;
            r_snd_cnt   <= '0;
            r_main_tgt  <= CNT_W'(RST_MAIN_FRAME);
            r_gfx_tgt   <= CNT_W'(RST_GFX_FRAME);
            r_snd_tgt   <= CNT_W'(RST_SOUND_FRAME);
            r_frame     <= '0;
            r_line      <= '0;
            r_pixel     <= '0;
            r_emitted   <= '0;
            r_sif       <= '0;
            r_out_valid <= 1'b0;
            r_beam_phase <= 1'b0;
            r_beam_ok   <= 1'b0;
            r_audio_ok  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_MAIN_FRAME:  r_main_fc  <= i_cfg.data;
                    REG_GFX_FRAME:   r_gfx_fc   <= i_cfg.data;
                    REG_SOUND_FRAME: r_snd_fc   <= i_cfg.data;
                    REG_VIDEO_FRAME: r_video_fc <= i_cfg.data;
                    REG_PIX_LINE:    r_ppl      <= i_cfg.data[PIX_W-1:0];
                    REG_VIS_LINES:   r_vis      <= i_cfg.data[LINE_W-1:0];
                    REG_TOT_LINES:   r_total    <= i_cfg.data[LINE_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == S_ADD) begin
                case (r_mode)
                    MODE_ADD_MAIN:  r_main_cnt <= r_main_cnt + CNT_W'(r_cyc);
                    MODE_ADD_GFX:   r_gfx_cnt  <= r_gfx_cnt + CNT_W'(r_cyc);
                    MODE_ADD_SOUND: r_snd_cnt  <= r_snd_cnt + CNT_W'(r_cyc);
                    MODE_RUN_FRAME: begin
                        r_main_tgt <= r_main_cnt + CNT_W'(r_main_fc);
                        r_gfx_tgt  <= r_gfx_cnt + CNT_W'(r_gfx_fc);
                        r_snd_tgt  <= r_snd_cnt + CNT_W'(r_snd_fc);
                        r_sif      <= '0;
                        r_frame    <= r_frame + FRAME_W'(1);
                    end
                    MODE_ADV_LINE: begin
                        // Past the last line the beam wraps and a new frame starts.
                        if (w_adv_line >= {1'b0, r_total}) begin
                            r_line  <= '0;
                            r_frame <= r_frame + FRAME_W'(1);
                        end else begin
                            r_line <= w_adv_line[LINE_W-1:0];
                        end
                        r_pixel <= '0;
                    end
                    default: ;
                endcase
            end

            if (r_state == S_LOAD) begin
                r_beam_phase <= 1'b0;
                r_beam_ok    <= !w_uses_beam;
                r_audio_ok   <= 1'b0;
            end

            if (r_state == S_DIV) begin
                if (w_beam_stat.done && !r_beam_phase) begin
                    r_beam_phase <= 1'b1;
                end
                if (w_beam_stat.done && r_beam_phase) begin
                    r_beam_ok <= 1'b1;
                end
                if (w_aud_stat.done) begin
                    r_audio_ok <= 1'b1;
                end
                if (w_both_done) begin
                    if (w_uses_beam) begin
                        r_line  <= w_new_line;
                        r_pixel <= w_beam_rem[PIX_W-1:0];
                    end
                    if (w_due_pos) begin
                        r_emitted <= w_expected;
                        r_sif     <= r_sif + w_due_full[CFG_W-1:0];
                    end
                end
            end

            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the item in work and of the result.
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_mode    <= i_item.mode;
            r_cyc     <= i_item.cycle_count;
            r_line_ev <= 1'b0;
            r_vb_ev   <= 1'b0;
            r_due     <= '0;
        end

        if ((r_state == S_ADD) && (r_mode == MODE_ADV_LINE)) begin
            r_line_ev <= 1'b1;
            if (w_adv_line >= {1'b0, r_total}) begin
                r_vb_ev <= (r_vis == '0);
            end else begin
                r_vb_ev <= (w_adv_line[LINE_W-1:0] == r_vis);
            end
        end

        if (r_state == S_MUL) begin
            r_plo <= (HALF_W + SR_W)'(r_gfx_cnt[HALF_W-1:0]) * (HALF_W + SR_W)'(SR_K);
            r_phi <= (HALF_W + SR_W)'(r_gfx_cnt[CNT_W-1:HALF_W]) * (HALF_W + SR_W)'(SR_K);
        end

        if ((r_state == S_DIV) && w_both_done) begin
            if (w_uses_beam) begin
                r_line_ev <= (w_new_line != r_line);
                r_vb_ev   <= (r_line < r_vis) && (w_new_line >= r_vis);
            end
            if (w_due_pos) begin
                r_due <= (|w_due_full[CNT_W-1:SAMP_W]) ? '1 : w_due_full[SAMP_W-1:0];
            end
        end

        if ((r_state == S_DONE) && w_out_free) begin
            r_out.scanline       <= r_line;
            r_out.pixel          <= r_pixel;
            r_out.scanline_event <= r_line_ev;
            r_out.vblank_event   <= r_vb_ev;
            r_out.new_samples    <= r_due;
            r_out.frame_number   <= r_frame;
            r_out.run_main       <= r_main_cnt < r_main_tgt;
            r_out.run_graphics   <= r_gfx_cnt < r_gfx_tgt;
            r_out.run_sound      <= r_snd_cnt < r_snd_tgt;
            r_out.frame_samples  <= r_sif;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.scanline       = r_out.scanline;
    assign o_result.pixel          = r_out.pixel;
    assign o_result.scanline_event = r_out.scanline_event;
    assign o_result.vblank_event   = r_out.vblank_event;
    assign o_result.new_samples    = r_out.new_samples;
    assign o_result.frame_number   = r_out.frame_number;
    assign o_result.run_main       = r_out.run_main;
    assign o_result.run_graphics   = r_out.run_graphics;
    assign o_result.run_sound      = r_out.run_sound;
    assign o_result.frame_samples  = r_out.frame_samples;

    // An accepted item always starts its work in the add state.
    a_accept_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> r_state == S_ADD)
        else $error("accepted item did not enter the add state");

    // Neither divider may still be running while the block waits for an item.
    a_idle_dividers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !w_beam_stat.busy && !w_aud_stat.busy)
        else $error("divider busy while idle");

    // Entering vertical blank always moves the scanline.
    a_vblank_moves_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.vblank_event |-> r_out.scanline_event)
        else $error("vblank event without scanline event");

    // A result leaving the done state lands in the output register.
    a_done_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && w_out_free |=> r_out_valid && r_state == S_IDLE)
        else $error("result not registered on completion");

    // A finished audio division leaves a remainder below the clock rate.
    a_audio_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_aud_stat.done |-> w_aud_rem < CLK_K)
        else $error("audio remainder not below the clock rate");

endmodule

`default_nettype wire

// File: tb/sv/emt_timing_checker.sv
// Scoreboard for the master timing unit: watches the item, configuration and
// result channels, keeps its own timing state and checks every result item.
// Depends on emt_pkg and the interfaces in emt_if.sv.
`default_nettype none

module emt_timing_checker import emt_pkg::*; #(
    parameter int CLOCK_HZ    = 13500000,
    parameter int SAMPLE_RATE = 32000
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    emt_item_if       i_item,
    emt_cfg_if        i_cfg,
    emt_result_if     i_result,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CNT_W-1:0] HZ64   = CNT_W'(CLOCK_HZ);
    localparam logic [CNT_W-1:0] RATE64 = CNT_W'(SAMPLE_RATE);

    // Shadow copy of the configuration registers.
    logic [CFG_W-1:0]  main_len, gfx_len, snd_len, vid_len;
    logic [PIX_W-1:0]  line_pix;
    logic [LINE_W-1:0] vis_lines, tot_lines;

    // Shadow timing state.
    logic [CNT_W-1:0]   main_cnt, gfx_cnt, snd_cnt;
    logic [CNT_W-1:0]   main_tgt, gfx_tgt, snd_tgt;
    logic [CNT_W-1:0]   samples_out;
    logic [FRAME_W-1:0] frame_cnt;
    logic [CFG_W-1:0]   frame_samps;
    logic [LINE_W-1:0]  beam_line;
    logic [PIX_W-1:0]   beam_pix;

    t_result status_due_q[$];
    int      results_seen;

    task automatic clear_timing();
        main_len    = RST_MAIN_FRAME;
        gfx_len     = RST_GFX_FRAME;
        snd_len     = RST_SOUND_FRAME;
        vid_len     = RST_VIDEO_FRAME;
        line_pix    = RST_PIX_LINE;
        vis_lines   = RST_VIS_LINES;
        tot_lines   = RST_TOT_LINES;
        main_cnt    = '0;
        gfx_cnt     = '0;
        snd_cnt     = '0;
        main_tgt    = CNT_W'(RST_MAIN_FRAME);
        gfx_tgt     = CNT_W'(RST_GFX_FRAME);
        snd_tgt     = CNT_W'(RST_SOUND_FRAME);
        samples_out = '0;
        frame_cnt   = '0;
        frame_samps = '0;
        beam_line   = '0;
        beam_pix    = '0;
    endtask

    // Beam position follows the master count; zero lengths count as one.
    task automatic refresh_beam(output logic line_ev, output logic vb_ev);
        logic [CNT_W-1:0]  flen, plen, pos, row;
        logic [LINE_W-1:0] old_line, new_line;
        flen = (vid_len == '0) ? CNT_W'(1) : CNT_W'(vid_len);
        plen = (line_pix == '0) ? CNT_W'(1) : CNT_W'(line_pix);
        pos = gfx_cnt % flen;
        row = pos / plen;
        old_line = beam_line;
        new_line = (row > CNT_W'({LINE_W{1'b1}})) ? {LINE_W{1'b1}} : row[LINE_W-1:0];
        beam_line = new_line;
        beam_pix = PIX_W'(pos % plen);
        line_ev = new_line != old_line;
        vb_ev = (old_line < vis_lines) && (new_line >= vis_lines);
    endtask

    // Samples owed by the master clock beyond those already emitted.
    task automatic collect_samples(output logic [CNT_W-1:0] owed);
        logic [CNT_W-1:0] whole, part, target;
        whole = gfx_cnt / HZ64;
        part = gfx_cnt % HZ64;
        target = whole * RATE64 + (part * RATE64) / HZ64;
        owed = '0;
        if (target > samples_out) begin
            owed = target - samples_out;
            samples_out = target;
            frame_samps = frame_samps + owed[CFG_W-1:0];
        end
    endtask

    task automatic predict_status(input logic [MODE_W-1:0] mode,
                                  input logic [CYC_W-1:0] cyc, output t_result r);
        logic             line_ev, vb_ev;
        logic [CNT_W-1:0] owed;
        logic [LINE_W:0]  next_line;
        line_ev = 1'b0;
        vb_ev = 1'b0;
        owed = '0;
        case (mode)
            MODE_ADD_MAIN: begin
                main_cnt = main_cnt + CNT_W'(cyc);
                refresh_beam(line_ev, vb_ev);
                collect_samples(owed);
            end
            MODE_ADD_GFX: begin
                gfx_cnt = gfx_cnt + CNT_W'(cyc);
                refresh_beam(line_ev, vb_ev);
                collect_samples(owed);
            end
            MODE_ADD_SOUND: begin
                snd_cnt = snd_cnt + CNT_W'(cyc);
                collect_samples(owed);
            end
            MODE_RUN_FRAME: begin
                main_tgt = main_cnt + CNT_W'(main_len);
                gfx_tgt = gfx_cnt + CNT_W'(gfx_len);
                snd_tgt = snd_cnt + CNT_W'(snd_len);
                frame_samps = '0;
                frame_cnt = frame_cnt + 1'b1;
            end
            MODE_ADV_LINE: begin
                next_line = {1'b0, beam_line} + 1'b1;
                if (next_line >= {1'b0, tot_lines}) begin
                    next_line = '0;
                    frame_cnt = frame_cnt + 1'b1;
                end
                beam_line = next_line[LINE_W-1:0];
                beam_pix = '0;
                line_ev = 1'b1;
                vb_ev = beam_line == vis_lines;
            end
            MODE_RECHECK: begin
                refresh_beam(line_ev, vb_ev);
                collect_samples(owed);
            end
            default: begin
            end
        endcase
        r.scanline       = beam_line;
        r.pixel          = beam_pix;
        r.scanline_event = line_ev;
        r.vblank_event   = vb_ev;
        r.new_samples    = (owed > CNT_W'({SAMP_W{1'b1}})) ? {SAMP_W{1'b1}}
                                                           : owed[SAMP_W-1:0];
        r.frame_number   = frame_cnt;
        r.run_main       = main_cnt < main_tgt;
        r.run_graphics   = gfx_cnt < gfx_tgt;
        r.run_sound      = snd_cnt < snd_tgt;
        r.frame_samples  = frame_samps;
    endtask

    task automatic note_failure(input string what);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t: result item %0d: %s", $time, results_seen, what);
    endtask

    task automatic compare_field(input string name, input logic [CNT_W-1:0] want,
                                 input logic [CNT_W-1:0] got);
        if (got !== want)
            note_failure($sformatf("%s expected %0h, got %0h", name, want, got));
    endtask

    task automatic compare_status(input t_result want, input t_result got);
        compare_field("scanline", CNT_W'(want.scanline), CNT_W'(got.scanline));
        compare_field("pixel", CNT_W'(want.pixel), CNT_W'(got.pixel));
        compare_field("scanline_event", CNT_W'(want.scanline_event),
                      CNT_W'(got.scanline_event));
        compare_field("vblank_event", CNT_W'(want.vblank_event), CNT_W'(got.vblank_event));
        compare_field("new_samples", CNT_W'(want.new_samples), CNT_W'(got.new_samples));
        compare_field("frame_number", CNT_W'(want.frame_number), CNT_W'(got.frame_number));
        compare_field("run_main", CNT_W'(want.run_main), CNT_W'(got.run_main));
        compare_field("run_graphics", CNT_W'(want.run_graphics), CNT_W'(got.run_graphics));
        compare_field("run_sound", CNT_W'(want.run_sound), CNT_W'(got.run_sound));
        compare_field("frame_samples", CNT_W'(want.frame_samples),
                      CNT_W'(got.frame_samples));
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_result want, got;
        if (!i_rst_n) begin
            clear_timing();
            status_due_q.delete();
            results_seen = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_MAIN_FRAME:  main_len  = i_cfg.data;
                    REG_GFX_FRAME:   gfx_len   = i_cfg.data;
                    REG_SOUND_FRAME: snd_len   = i_cfg.data;
                    REG_VIDEO_FRAME: vid_len   = i_cfg.data;
                    REG_PIX_LINE:    line_pix  = i_cfg.data[PIX_W-1:0];
                    REG_VIS_LINES:   vis_lines = i_cfg.data[LINE_W-1:0];
                    REG_TOT_LINES:   tot_lines = i_cfg.data[LINE_W-1:0];
                    default: begin
                    end
                endcase
            end
            // The result leaving now belongs to an older item, so it is
            // checked before the item accepted at this edge is predicted.
            if (i_result.valid && i_result.ready) begin
                got.scanline       = i_result.scanline;
                got.pixel          = i_result.pixel;
                got.scanline_event = i_result.scanline_event;
                got.vblank_event   = i_result.vblank_event;
                got.new_samples    = i_result.new_samples;
                got.frame_number   = i_result.frame_number;
                got.run_main       = i_result.run_main;
                got.run_graphics   = i_result.run_graphics;
                got.run_sound      = i_result.run_sound;
                got.frame_samples  = i_result.frame_samples;
                if (status_due_q.size() == 0) begin
                    note_failure("arrived with no item waiting for it");
                end else begin
                    want = status_due_q.pop_front();
                    compare_status(want, got);
                end
                results_seen++;
            end
            if (i_item.valid && i_item.ready) begin
                predict_status(i_item.mode, i_item.cycle_count, want);
                status_due_q.push_back(want);
            end
        end
        o_pending <= status_due_q.size();
    end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Top of the master timing unit testbench: clock, reset, item and
// configuration stimulus, result back-pressure and the verdict.
// Depends on emt_pkg, emt_if.sv, emt_timing_checker and the unit itself.
`default_nettype none

module tb import emt_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLOCK_HZ    = 13500000;
    localparam int SAMPLE_RATE = 32000;

    // Codes outside the defined sets: two spare modes and a spare register.
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
    localparam logic [IDX_W-1:0]  REG_SPARE    = 3'd7;

    // Random part: one phase per configuration, one of them at the maximum
    // of every register.
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 222;
    localparam int MAX_PHASE       = 2;

    // The long receiver stall starts after this many items and lasts long
    // enough for the unit to finish its item and refuse the next one.
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 600;

    // Quiet time after the last result, a little above the slowest item.
    localparam int TAIL_CYCLES = 120;

    typedef struct {
        logic [CFG_W-1:0]  main_len;
        logic [CFG_W-1:0]  gfx_len;
        logic [CFG_W-1:0]  snd_len;
        logic [CFG_W-1:0]  vid_len;
        logic [PIX_W-1:0]  line_pix;
        logic [LINE_W-1:0] vis;
        logic [LINE_W-1:0] tot;
    } t_setup;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_sent;
    int   tx_burst;
    logic held_off;

    // Current register values, used to shape cycle counts to the beam geometry.
    t_setup setup = '{RST_MAIN_FRAME, RST_GFX_FRAME, RST_SOUND_FRAME, RST_VIDEO_FRAME,
                      RST_PIX_LINE, RST_VIS_LINES, RST_TOT_LINES};

    emt_item_if   item_ch ();
    emt_cfg_if    cfg_ch ();
    emt_result_if res_ch ();

    emulator_master_timing_unit #(
        .CLOCK_HZ   (CLOCK_HZ),
        .SAMPLE_RATE(SAMPLE_RATE)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .i_cfg   (cfg_ch),
        .o_result(res_ch)
    );

    emt_timing_checker #(
        .CLOCK_HZ   (CLOCK_HZ),
        .SAMPLE_RATE(SAMPLE_RATE)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .i_cfg       (cfg_ch),
        .i_result    (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly no gap or a short one; now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 88) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // Offers one item and holds it until the unit takes it. Valid stays high
    // when no gap follows, so back-to-back items never lower and raise it
    // within one time step.
    task automatic put_item(input logic [MODE_W-1:0] mode, input logic [CYC_W-1:0] cyc);
        int unsigned gap;
        item_ch.valid <= 1'b1;
        item_ch.mode <= mode;
        item_ch.cycle_count <= cyc;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
        if (tx_burst != 0) begin
            tx_burst--;
            gap = 0;
        end else begin
            gap = idle_len();
            if ($urandom_range(0, 19) == 0)
                tx_burst = $urandom_range(10, 40);
        end
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering items and waits until every result item has come back.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Leaves valid high so that a following write can go out on the next edge.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Registers change only with the unit idle, so the pipeline is drained
    // first. Every register is rewritten in each phase.
    task automatic load_setup(input t_setup s);
        drain_results();
        write_reg(REG_MAIN_FRAME, s.main_len);
        write_reg(REG_GFX_FRAME, s.gfx_len);
        write_reg(REG_SOUND_FRAME, s.snd_len);
        write_reg(REG_VIDEO_FRAME, s.vid_len);
        write_reg(REG_PIX_LINE, CFG_W'(s.line_pix));
        write_reg(REG_VIS_LINES, CFG_W'(s.vis));
        write_reg(REG_TOT_LINES, CFG_W'(s.tot));
        cfg_ch.valid <= 1'b0;
        setup = s;
    endtask

    function automatic logic [CFG_W-1:0] pick_frame_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 10) return CFG_W'(1);
        if (p < 20) return '1;
        return CFG_W'($urandom_range(1, 500000));
    endfunction

    // Random geometry: short frames are favored so that line wraps and
    // vertical blank come often; zero lengths and extremes show up too.
    function automatic t_setup random_setup();
        t_setup s;
        int unsigned p;
        s.main_len = pick_frame_len();
        s.gfx_len = pick_frame_len();
        s.snd_len = pick_frame_len();
        p = $urandom_range(0, 99);
        if (p < 5) s.line_pix = '0;
        else if (p < 15) s.line_pix = PIX_W'(1);
        else if (p < 25) s.line_pix = '1;
        else s.line_pix = PIX_W'($urandom_range(16, 1200));
        p = $urandom_range(0, 99);
        if (p < 20) s.tot = LINE_W'($urandom_range(1, 16));
        else if (p < 30) s.tot = '1;
        else s.tot = LINE_W'($urandom_range(17, 400));
        s.vis = ($urandom_range(0, 9) == 0) ? '1 : LINE_W'($urandom_range(1, s.tot));
        p = $urandom_range(0, 99);
        if (p < 40) s.vid_len = CFG_W'(s.line_pix) * CFG_W'(s.tot);
        else if (p < 45) s.vid_len = '0;
        else if (p < 55) s.vid_len = CFG_W'(1);
        else if (p < 65) s.vid_len = '1;
        else s.vid_len = CFG_W'($urandom_range(1000, 500000));
        return s;
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 15) return MODE_ADD_MAIN;
        if (p < 45) return MODE_ADD_GFX;
        if (p < 58) return MODE_ADD_SOUND;
        if (p < 66) return MODE_RUN_FRAME;
        if (p < 84) return MODE_ADV_LINE;
        if (p < 94) return MODE_RECHECK;
        return $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
    endfunction

    // Cycle counts: small steps, whole lines, parts of a frame, and full
    // 32-bit values for large sample steps and the counter targets.
    function automatic logic [CYC_W-1:0] pick_cycles();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 30) return CYC_W'($urandom_range(0, 2000));
        if (p < 55) return CYC_W'(setup.line_pix) * $urandom_range(0, 4) + $urandom_range(0, 3);
        if (p < 70) return setup.vid_len >> $urandom_range(0, 8);
        if (p < 90) return $urandom();
        if (p < 95) return '0;
        return '1;
    endfunction

    // Result side: runs of ready with random stalls between them, plus one
    // long hold-off that backs the unit up into its input.
    initial begin
        int unsigned on_len, off_len;
        held_off = 1'b0;
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held_off && items_sent >= HOLD_AFTER) begin
                held_off = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            on_len = $urandom_range(1, 24);
            off_len = idle_len();
            res_ch.ready <= 1'b1;
            repeat (on_len) @(posedge i_clk);
            if (off_len != 0) begin
                res_ch.ready <= 1'b0;
                repeat (off_len) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_setup s;
        items_sent = 0;
        tx_burst = 0;
        i_rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.mode <= MODE_RECHECK;
        item_ch.cycle_count <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_MAIN_FRAME;
        cfg_ch.data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A write to the unused register index must leave everything alone.
        write_reg(REG_SPARE, $urandom());
        cfg_ch.valid <= 1'b0;

        // Reset geometry: walk the beam one line, into vertical blank and
        // around the frame, then push every counter past its target and
        // saturate the sample count with a full 32-bit step.
        put_item(MODE_RECHECK, '0);
        put_item(MODE_ADD_MAIN, '0);
        put_item(MODE_ADD_GFX, 32'd1);
        put_item(MODE_ADD_GFX, 32'd857);
        put_item(MODE_ADD_GFX, 32'd205062);
        put_item(MODE_ADD_GFX, 32'd19080);
        put_item(MODE_ADD_SOUND, '1);
        put_item(MODE_ADD_MAIN, '1);
        put_item(MODE_RUN_FRAME, $urandom());
        put_item(MODE_ADD_GFX, '1);
        put_item(MODE_ADV_LINE, $urandom());
        put_item(MODE_RECHECK, $urandom());
        put_item(MODE_SPARE_A, 32'h1234_5678);
        put_item(MODE_SPARE_B, '1);

        // A three-line frame with blank at line 2: advancing lines hits the
        // blank and wraps, bumping the frame number.
        s = '{32'd1, 32'd1, 32'd1, 32'd12, 12'd4, 10'd2, 10'd3};
        load_setup(s);
        put_item(MODE_RUN_FRAME, '0);
        repeat (4) put_item(MODE_ADV_LINE, $urandom());
        put_item(MODE_ADD_GFX, 32'd5);
        put_item(MODE_ADD_GFX, 32'd3);

        // Zero frame and line lengths behave as a length of one.
        s = '{32'd1, 32'd1, 32'd1, 32'd0, 12'd0, 10'd1, 10'd1};
        load_setup(s);
        put_item(MODE_ADD_GFX, 32'd7);
        put_item(MODE_ADV_LINE, '0);
        put_item(MODE_RECHECK, '0);

        // One-cycle lines over a huge frame: the scanline saturates at its top.
        s = '{'1, '1, '1, '1, 12'd0, '1, '1};
        load_setup(s);
        put_item(MODE_ADD_GFX, 32'd1);
        put_item(MODE_RECHECK, '0);
        put_item(MODE_ADV_LINE, '0);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == MAX_PHASE)
                s = '{'1, '1, '1, '1, '1, '1, '1};
            else
                s = random_setup();
            load_setup(s);
            repeat (ITEMS_PER_PHASE) put_item(pick_mode(), pick_cycles());
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog, several times the slowest correct run.
    initial begin
        #(20_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/emt_pkg.sv
sv/emt_if.sv
sv/emt_serial_div.sv
sv/emulator_master_timing_unit.sv
tb/sv/emt_timing_checker.sv
tb/sv/tb.sv
